>>> rtl/pse_pkg.sv
// Shared types, codes and helpers for the postfix stack evaluator.
`default_nettype none

package pse_pkg;

  // Field widths
  localparam int unsigned VAL_W     = 48;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned ST_W      = 3;
  localparam int unsigned CNT_OUT_W = 7;

  // Parameter defaults
  localparam int unsigned DEF_STACK_DEPTH   = 64;
  localparam int unsigned DEF_FRACTION_BITS = 16;

  // Token codes
  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
  localparam logic [OP_W-1:0] OP_END  = 3'd5;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_UNDER    = 3'd1;
  localparam logic [ST_W-1:0] ST_DIVZ     = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
  localparam logic [ST_W-1:0] ST_UNKNOWN  = 3'd4;
  localparam logic [ST_W-1:0] ST_BADCOUNT = 3'd5;

  // Saturation on wide magnitudes
  localparam int unsigned       SAT_W   = 128;
  localparam logic [SAT_W-1:0]  NEG_LIM = SAT_W'(1) << (VAL_W - 1);
  localparam logic [SAT_W-1:0]  POS_LIM = NEG_LIM - SAT_W'(1);

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic start;
    logic commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic long_op;
    logic res_vld;
    logic out_free;
  } stat_t;

  // Absolute value of a 48-bit two's complement word, as unsigned
  function automatic logic [VAL_W-1:0] mag48(input logic [VAL_W-1:0] x);
    return x[VAL_W-1] ? (~x + VAL_W'(1)) : x;
  endfunction

  // Apply sign to a magnitude and clamp to the 48-bit signed range
  function automatic logic [VAL_W-1:0] sat_mag(input logic [SAT_W-1:0] mag,
                                               input logic neg);
    logic [SAT_W-1:0] m_n;
    m_n = ~mag + SAT_W'(1);
    if (neg) begin
      if (mag >= NEG_LIM) return NEG_LIM[VAL_W-1:0];
      return m_n[VAL_W-1:0];
    end
    if (mag > POS_LIM) return POS_LIM[VAL_W-1:0];
    return mag[VAL_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/pse_in_if.sv
// Token input channel: valid/ready with op and operand.
`default_nettype none

interface pse_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [pse_pkg::OP_W-1:0]             op;
  logic signed [pse_pkg::VAL_W-1:0]     operand_value;

  modport source (output valid, output op, output operand_value, input ready);
  modport sink   (input valid, input op, input operand_value, output ready);
endinterface

`default_nettype wire

>>> rtl/pse_out_if.sv
// Result output channel: valid/ready with top value, count, status, final flag.
`default_nettype none

interface pse_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pse_pkg::VAL_W-1:0]     top_value;
  logic [pse_pkg::CNT_OUT_W-1:0]        stack_count;
  logic [pse_pkg::ST_W-1:0]             status;
  logic                                 is_final;

  modport source (output valid, output top_value, output stack_count, output status,
                  output is_final, input ready);
  modport sink   (input valid, input top_value, input stack_count, input status,
                  input is_final, output ready);
endinterface

`default_nettype wire

>>> rtl/postfix_stack_evaluator_top.sv
// Top level of the postfix stack evaluator.
//
//   Channel  Dir  Beat contents
//   in_i     in   op, operand_value
//   out_o    out  top_value, stack_count, status, is_final
//
// Push, end, error and ignored tokens are handled at accept. Their beat is
// registered, and the next token can enter in the same cycle that beat is taken.
// Add and subtract pass through accept, fetch of the second entry from
// the stack memory, and commit. Multiply runs through four 24x24 partial
// products plus rounding. Divide runs through the one-bit-per-cycle divider.
// Reset clears count and error; the stack memory needs no clearing. A stalled
// output holds the token input off.
`default_nettype none

module postfix_stack_evaluator_top #(
  parameter int unsigned STACK_DEPTH   = pse_pkg::DEF_STACK_DEPTH,
  parameter int unsigned FRACTION_BITS = pse_pkg::DEF_FRACTION_BITS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pse_in_if.sink     in_i,
  pse_out_if.source  out_o
);

  pse_pkg::cmd_t  cmd;
  pse_pkg::stat_t stat;

  pse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pse_dp #(
    .STACK_DEPTH   (STACK_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .op_i        (in_i.op),
    .val_i       (in_i.operand_value),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_top_o   (out_o.top_value),
    .out_cnt_o   (out_o.stack_count),
    .out_st_o    (out_o.status),
    .out_fin_o   (out_o.is_final)
  );

endmodule

`default_nettype wire

>>> rtl/pse_mul.sv
// Fixed-point multiplier: 24x24 partial products one after another, round, saturate.
`default_nettype none

module pse_mul #(
  parameter int unsigned FRACTION_BITS = pse_pkg::DEF_FRACTION_BITS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [pse_pkg::VAL_W-1:0]  a_i,
  input  wire logic [pse_pkg::VAL_W-1:0]  b_i,
  output logic                            done_o,
  output logic [pse_pkg::VAL_W-1:0]       res_o
);

  localparam int unsigned VW = pse_pkg::VAL_W;
  localparam int unsigned HW = VW / 2;
  localparam int unsigned PW = 2 * VW;
  localparam logic [PW-1:0] HALF = (PW'(1) << FRACTION_BITS) >> 1;

  logic          busy_q, done_q;
  logic [2:0]    step_q;
  logic [VW-1:0] ua_q, ub_q, prod_q, res_q;
  logic          neg_q;
  logic [1:0]    sh_q;
  logic [PW-1:0] acc_q;

  logic [HW-1:0] a_part, b_part;
  logic [PW-1:0] prod_sh, rnd;

  // operand halves for the current partial product
  assign a_part = step_q[1] ? ua_q[VW-1:HW] : ua_q[HW-1:0];
  assign b_part = step_q[0] ? ub_q[VW-1:HW] : ub_q[HW-1:0];

  // align previous partial product
  always_comb begin
    case (sh_q)
      2'd0:    prod_sh = PW'(prod_q);
      2'd1:    prod_sh = PW'(prod_q) << HW;
      2'd2:    prod_sh = PW'(prod_q) << VW;
      default: prod_sh = '0;
    endcase
  end

  assign rnd = (acc_q + HALF) >> FRACTION_BITS;

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd5) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // products, accumulation, rounding
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ua_q  <= pse_pkg::mag48(a_i);
      ub_q  <= pse_pkg::mag48(b_i);
      neg_q <= a_i[VW-1] ^ b_i[VW-1];
      acc_q <= '0;
    end else if (busy_q) begin
      if (step_q < 3'd4) begin
        prod_q <= a_part * b_part;
        sh_q   <= {1'b0, step_q[1]} + {1'b0, step_q[0]};
      end
      if (step_q >= 3'd1 && step_q <= 3'd4) acc_q <= acc_q + prod_sh;
      if (step_q == 3'd5) res_q <= pse_pkg::sat_mag(pse_pkg::SAT_W'(rnd), neg_q);
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

>>> rtl/pse_div.sv
// Fixed-point divider: restoring division one quotient bit per cycle, round, saturate.
`default_nettype none

module pse_div #(
  parameter int unsigned FRACTION_BITS = pse_pkg::DEF_FRACTION_BITS
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [pse_pkg::VAL_W-1:0]  a_i,
  input  wire logic [pse_pkg::VAL_W-1:0]  b_i,
  output logic                            done_o,
  output logic [pse_pkg::VAL_W-1:0]       res_o
);

  localparam int unsigned VW  = pse_pkg::VAL_W;
  localparam int unsigned NW  = VW + FRACTION_BITS;
  localparam int unsigned RW  = VW + 1;
  localparam int unsigned CTW = $clog2(NW + 1);

  logic           busy_q, done_q;
  logic [CTW-1:0] cnt_q;
  logic [NW-1:0]  n_q;
  logic [RW-1:0]  rem_q;
  logic [VW-1:0]  ub_q, res_q;
  logic           neg_q;

  logic [RW-1:0]  trial;
  logic           ge;
  logic           rnd_up;

  // one restoring step
  assign trial  = {rem_q[RW-2:0], n_q[NW-1]};
  assign ge     = trial >= RW'(ub_q);
  assign rnd_up = {rem_q, 1'b0} >= (RW + 1)'(ub_q);

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CTW'(NW);
      end else if (busy_q) begin
        if (cnt_q != '0) begin
          cnt_q <= cnt_q - CTW'(1);
        end else begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // numerator shifts out, quotient shifts in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= NW'(pse_pkg::mag48(a_i)) << FRACTION_BITS;
      ub_q  <= pse_pkg::mag48(b_i);
      rem_q <= '0;
      neg_q <= a_i[VW-1] ^ b_i[VW-1];
    end else if (busy_q) begin
      if (cnt_q != '0) begin
        rem_q <= ge ? (trial - RW'(ub_q)) : trial;
        n_q   <= {n_q[NW-2:0], ge};
      end else begin
        res_q <= pse_pkg::sat_mag(pse_pkg::SAT_W'(n_q) + pse_pkg::SAT_W'(rnd_up), neg_q);
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

>>> rtl/pse_ctrl.sv
// Token sequencer: accepts tokens and steps executable operator tokens through fetch, run, commit.
`default_nettype none

module pse_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire pse_pkg::stat_t  stat_i,
  output pse_pkg::cmd_t        cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;

  logic [1:0] state_q, state_d;

  // handshake and commands
  assign in_ready_o    = (state_q == S_IDLE) && stat_i.out_free;
  assign cmd_o.accept  = in_valid_i && in_ready_o;
  assign cmd_o.start   = (state_q == S_FETCH);
  assign cmd_o.commit  = (state_q == S_RUN) && stat_i.res_vld && stat_i.out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (cmd_o.accept && stat_i.long_op) state_d = S_FETCH;
      S_FETCH: state_d = S_RUN;
      S_RUN:   if (cmd_o.commit) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

`default_nettype wire

>>> rtl/pse_dp.sv
// Datapath: value stack memory, count, sticky error, arithmetic units, result register.
`default_nettype none

module pse_dp #(
  parameter int unsigned STACK_DEPTH   = pse_pkg::DEF_STACK_DEPTH,
  parameter int unsigned FRACTION_BITS = pse_pkg::DEF_FRACTION_BITS
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire pse_pkg::cmd_t                      cmd_i,
  output pse_pkg::stat_t                          stat_o,
  input  wire logic [pse_pkg::OP_W-1:0]           op_i,
  input  wire logic [pse_pkg::VAL_W-1:0]          val_i,
  input  wire logic                               out_ready_i,
  output logic                                    out_valid_o,
  output logic [pse_pkg::VAL_W-1:0]               out_top_o,
  output logic [pse_pkg::CNT_OUT_W-1:0]           out_cnt_o,
  output logic [pse_pkg::ST_W-1:0]                out_st_o,
  output logic                                    out_fin_o
);

  localparam int unsigned VW = pse_pkg::VAL_W;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic [VW-1:0]              stk_mem [STACK_DEPTH];
  logic [VW-1:0]              rd_q, top_q, res_q;
  logic [CW-1:0]              cnt_q;
  logic [pse_pkg::ST_W-1:0]   err_q;
  logic [pse_pkg::OP_W-1:0]   op_q;
  logic                       res_vld_q, out_valid_q;
  logic [VW-1:0]              out_top_q;
  logic [pse_pkg::CNT_OUT_W-1:0] out_cnt_q;
  logic [pse_pkg::ST_W-1:0]   out_st_q;
  logic                       out_fin_q;

  logic [CW-1:0]              nx_cnt, cnt_m2;
  logic [pse_pkg::ST_W-1:0]   nx_err, o_st;
  logic [VW-1:0]              nx_top, o_top, cur_top;
  logic                       push_we, long_op, o_fin, emit;
  logic [AW-1:0]              addr2;
  logic [VW:0]                sum;
  logic [VW-1:0]              sum_sat;
  logic                       mul_done, div_done;
  logic [VW-1:0]              mul_res, div_res;

  assign cnt_m2  = cnt_q - CW'(2);
  assign addr2   = cnt_m2[AW-1:0];
  assign cur_top = (cnt_q != '0) ? top_q : '0;

  // token decode at accept
  always_comb begin
    nx_cnt  = cnt_q;
    nx_err  = err_q;
    nx_top  = top_q;
    push_we = 1'b0;
    long_op = 1'b0;
    o_top   = cur_top;
    o_fin   = 1'b0;
    o_st    = pse_pkg::ST_OK;
    if (op_i == pse_pkg::OP_END) begin
      nx_cnt = '0;
      nx_err = pse_pkg::ST_OK;
      o_fin  = 1'b1;
      if (err_q != pse_pkg::ST_OK) begin
        o_st  = err_q;
        o_top = '0;
      end else if (cnt_q == CW'(1)) begin
        o_st  = pse_pkg::ST_OK;
        o_top = top_q;
      end else begin
        o_st  = pse_pkg::ST_BADCOUNT;
        o_top = '0;
      end
    end else begin
      if (err_q != pse_pkg::ST_OK) begin
        // pending error: token ignored
      end else if (op_i == pse_pkg::OP_PUSH) begin
        if (cnt_q == CW'(STACK_DEPTH)) begin
          nx_err = pse_pkg::ST_FULL;
        end else begin
          push_we = 1'b1;
          nx_cnt  = cnt_q + CW'(1);
          nx_top  = val_i;
          o_top   = val_i;
        end
      end else if (op_i inside {pse_pkg::OP_ADD, pse_pkg::OP_SUB,
                                pse_pkg::OP_MUL, pse_pkg::OP_DIV}) begin
        if (cnt_q < CW'(2))
          nx_err = pse_pkg::ST_UNDER;
        else if (op_i == pse_pkg::OP_DIV && top_q == '0)
          nx_err = pse_pkg::ST_DIVZ;
        else
          long_op = 1'b1;
      end else begin
        nx_err = pse_pkg::ST_UNKNOWN;
      end
      o_st = nx_err;
    end
  end

  // add / subtract with saturation: left is rd_q, right is top_q
  always_comb begin
    if (op_q == pse_pkg::OP_SUB) sum = {rd_q[VW-1], rd_q} - {top_q[VW-1], top_q};
    else                         sum = {rd_q[VW-1], rd_q} + {top_q[VW-1], top_q};
    if (sum[VW] != sum[VW-1])
      sum_sat = sum[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
    else
      sum_sat = sum[VW-1:0];
  end

  pse_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && op_q == pse_pkg::OP_MUL),
    .a_i     (rd_q),
    .b_i     (top_q),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  pse_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && op_q == pse_pkg::OP_DIV),
    .a_i     (rd_q),
    .b_i     (top_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  assign emit = (cmd_i.accept && !long_op) || cmd_i.commit;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      err_q       <= pse_pkg::ST_OK;
      res_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        cnt_q <= nx_cnt;
        err_q <= nx_err;
      end else if (cmd_i.commit) begin
        cnt_q <= cnt_q - CW'(1);
      end
      if (cmd_i.commit)
        res_vld_q <= 1'b0;
      else if ((cmd_i.start && (op_q == pse_pkg::OP_ADD || op_q == pse_pkg::OP_SUB))
               || mul_done || div_done)
        res_vld_q <= 1'b1;
      if (emit)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      top_q <= nx_top;
      op_q  <= op_i;
    end else if (cmd_i.commit) begin
      top_q <= res_q;
    end
    if (cmd_i.start && (op_q == pse_pkg::OP_ADD || op_q == pse_pkg::OP_SUB))
      res_q <= sum_sat;
    else if (mul_done)
      res_q <= mul_res;
    else if (div_done)
      res_q <= div_res;
    if (cmd_i.commit) begin
      out_top_q <= res_q;
      out_cnt_q <= pse_pkg::CNT_OUT_W'(cnt_q - CW'(1));
      out_st_q  <= pse_pkg::ST_OK;
      out_fin_q <= 1'b0;
    end else if (cmd_i.accept && !long_op) begin
      out_top_q <= o_top;
      out_cnt_q <= pse_pkg::CNT_OUT_W'(nx_cnt);
      out_st_q  <= o_st;
      out_fin_q <= o_fin;
    end
  end

  // stack memory: one write port, one registered read of the second entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && push_we) stk_mem[cnt_q[AW-1:0]] <= val_i;
    else if (cmd_i.commit)       stk_mem[addr2] <= res_q;
    rd_q <= stk_mem[addr2];
  end

  assign stat_o.long_op  = long_op;
  assign stat_o.res_vld  = res_vld_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_top_o   = out_top_q;
  assign out_cnt_o   = out_cnt_q;
  assign out_st_o    = out_st_q;
  assign out_fin_o   = out_fin_q;

endmodule

`default_nettype wire

>>> verif/pse_checker.sv
// Checker for the postfix stack evaluator: predicts each result beat and compares.
`timescale 1ns / 1ps

module pse_checker (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pse_in_if.sink     tok_i,
  pse_out_if.sink    res_i,
  output int         fail_count_o,
  output int         pending_o
);

  localparam int DEPTH = pse_pkg::DEF_STACK_DEPTH;
  localparam int FRAC  = pse_pkg::DEF_FRACTION_BITS;
  localparam int VW    = pse_pkg::VAL_W;

  typedef struct packed {
    logic [VW-1:0]                 top_value;
    logic [pse_pkg::CNT_OUT_W-1:0] stack_count;
    logic [pse_pkg::ST_W-1:0]      status;
    logic                          is_final;
  } rpn_result_t;

  logic signed [VW-1:0]     eval_stack [DEPTH];
  int                       depth_used;
  logic [pse_pkg::ST_W-1:0] held_err;
  rpn_result_t              expected_results [$];

  // Clamp a signed magnitude to the 48-bit signed range
  function automatic logic [VW-1:0] clamp48(input logic [255:0] mag, input logic neg);
    logic [255:0] lim;
    lim = 256'(1) << (VW - 1);
    if (neg) begin
      if (mag >= lim) return lim[VW-1:0];
      return 48'(-mag);
    end
    if (mag > lim - 1) return 48'(lim - 1);
    return mag[VW-1:0];
  endfunction

  function automatic logic [VW-1:0] abs48(input logic signed [VW-1:0] x);
    return x < 0 ? 48'(-x) : 48'(x);
  endfunction

  // Fixed-point arithmetic for one operator
  function automatic logic [VW-1:0] combine(input logic [pse_pkg::OP_W-1:0] op,
                                           input logic signed [VW-1:0] l,
                                           input logic signed [VW-1:0] r);
    logic signed [VW+1:0] s;
    logic [255:0] ua, ub, p, q, rm;
    logic neg;
    neg = (l < 0) != (r < 0);
    ua  = 256'(abs48(l));
    ub  = 256'(abs48(r));
    case (op)
      pse_pkg::OP_ADD: begin
        s = 50'(l) + 50'(r);
        return clamp48(256'(s < 0 ? -s : s), s < 0);
      end
      pse_pkg::OP_SUB: begin
        s = 50'(l) - 50'(r);
        return clamp48(256'(s < 0 ? -s : s), s < 0);
      end
      pse_pkg::OP_MUL: begin
        p = ua * ub;
        if (FRAC > 0) p = (p + (256'(1) << (FRAC - 1))) >> FRAC;
        return clamp48(p, neg);
      end
      default: begin
        q  = (ua << FRAC) / ub;
        rm = (ua << FRAC) % ub;
        if (rm * 2 >= ub) q = q + 1;
        return clamp48(q, neg);
      end
    endcase
  endfunction

  // Advance the predicted stack by one token and queue its result
  task automatic predict_token(input logic [pse_pkg::OP_W-1:0] op,
                               input logic signed [VW-1:0] v);
    rpn_result_t e;
    e = '0;
    if (op == pse_pkg::OP_END) begin
      if (held_err != pse_pkg::ST_OK) e.status = held_err;
      else if (depth_used == 1) e.top_value = eval_stack[0];
      else e.status = pse_pkg::ST_BADCOUNT;
      e.is_final = 1'b1;
      depth_used = 0;
      held_err   = pse_pkg::ST_OK;
    end else begin
      if (held_err == pse_pkg::ST_OK) begin
        if (op == pse_pkg::OP_PUSH) begin
          if (depth_used >= DEPTH) held_err = pse_pkg::ST_FULL;
          else begin
            eval_stack[depth_used] = v;
            depth_used++;
          end
        end else if (op >= pse_pkg::OP_ADD && op <= pse_pkg::OP_DIV) begin
          if (depth_used < 2) held_err = pse_pkg::ST_UNDER;
          else if (op == pse_pkg::OP_DIV && eval_stack[depth_used-1] == 0)
            held_err = pse_pkg::ST_DIVZ;
          else begin
            eval_stack[depth_used-2] =
              combine(op, eval_stack[depth_used-2], eval_stack[depth_used-1]);
            depth_used--;
          end
        end else begin
          held_err = pse_pkg::ST_UNKNOWN;
        end
      end
      if (depth_used > 0) e.top_value = eval_stack[depth_used-1];
      e.stack_count = 7'(depth_used);
      e.status      = held_err;
    end
    expected_results.push_back(e);
  endtask

  assign pending_o = expected_results.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rpn_result_t e, got;
    if (!rst_ni) begin
      depth_used    = 0;
      held_err      = pse_pkg::ST_OK;
      fail_count_o <= 0;
    end else begin
      if (tok_i.valid && tok_i.ready) predict_token(tok_i.op, tok_i.operand_value);
      if (res_i.valid && res_i.ready) begin
        got = '{res_i.top_value, res_i.stack_count, res_i.status, res_i.is_final};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat %h", $realtime, got);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_results.pop_front();
          if (e !== got) begin
            $display("%0t: mismatch expected top=%h cnt=%0d st=%0d fin=%0b", $realtime,
                     e.top_value, e.stack_count, e.status, e.is_final);
            $display("%0t:          actual   top=%h cnt=%0d st=%0d fin=%0b", $realtime,
                     got.top_value, got.stack_count, got.status, got.is_final);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

>>> verif/tb_postfix_stack_evaluator_top.sv
// Testbench top for the postfix stack evaluator: token stimulus and verdict.
`timescale 1ns / 1ps

module tb_postfix_stack_evaluator_top;

  localparam int RANDOM_EXPRS = 170;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int VW           = pse_pkg::VAL_W;

  // Undefined token codes
  localparam logic [pse_pkg::OP_W-1:0] OP_BAD_LO = 3'd6;
  localparam logic [pse_pkg::OP_W-1:0] OP_BAD_HI = 3'd7;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycle_count;
  int   out_wait;

  pse_in_if  tok_ch ();
  pse_out_if res_ch ();

  postfix_stack_evaluator_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (tok_ch.sink),
    .out_o (res_ch.source)
  );

  pse_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_i       (tok_ch.sink),
    .res_i       (res_ch.sink),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side back-pressure: ready drops after each taken beat, plus a random stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      out_wait     <= 0;
    end else if (out_wait > 0) begin
      res_ch.ready <= 1'b0;
      out_wait     <= out_wait - 1;
    end else if (res_ch.ready && res_ch.valid) begin
      out_wait     <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  function automatic logic [VW-1:0] rand_val();
    case ($urandom_range(0, 6))
      0: return {1'b0, {(VW-1){1'b1}}};
      1: return {1'b1, {(VW-1){1'b0}}};
      2: return '0;
      3: return 48'($signed(32'($urandom_range(0, 8))) - 4) << 16;
      4: return 48'($signed({$urandom, $urandom}) >>> $urandom_range(0, 40));
      default: return 48'($signed($urandom)) <<< $urandom_range(0, 16);
    endcase
  endfunction

  // Send one token, with a random gap before it
  task automatic send_token(input logic [pse_pkg::OP_W-1:0] op, input logic [VW-1:0] v);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      tok_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tok_ch.valid         <= 1'b1;
    tok_ch.op            <= op;
    tok_ch.operand_value <= v;
    @(posedge clk_i);
    while (!tok_ch.ready) @(posedge clk_i);
  endtask

  // Well-formed expression of random shape, sometimes broken
  task automatic send_expression();
    int depth, n, i;
    logic [pse_pkg::OP_W-1:0] op;
    depth = 0;
    n = $urandom_range(1, 8);
    for (i = 0; i < n || depth > 1; i++) begin
      if (depth < 2 || ($urandom_range(0, 1) == 0 && i < n)) begin
        send_token(pse_pkg::OP_PUSH, rand_val());
        depth++;
      end else begin
        op = 3'($urandom_range(pse_pkg::OP_ADD, pse_pkg::OP_DIV));
        if ($urandom_range(0, 30) == 0) op = 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
        send_token(op, rand_val());
        depth--;
      end
      if ($urandom_range(0, 40) == 0) break;
    end
    if ($urandom_range(0, 15) == 0)
      send_token(3'($urandom_range(pse_pkg::OP_ADD, pse_pkg::OP_DIV)), rand_val());
    send_token(pse_pkg::OP_END, rand_val());
  endtask

  initial begin
    int i;
    cycle_count          = 0;
    rst_ni               = 1'b0;
    tok_ch.valid         = 1'b0;
    tok_ch.op            = pse_pkg::OP_PUSH;
    tok_ch.operand_value = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: end on an empty stack, underflow, each operator at extremes
    send_token(pse_pkg::OP_END, '0);
    send_token(pse_pkg::OP_ADD, '0);
    send_token(pse_pkg::OP_END, '0);
    send_token(pse_pkg::OP_PUSH, {1'b0, {47{1'b1}}});
    send_token(pse_pkg::OP_PUSH, {1'b0, {47{1'b1}}});
    send_token(pse_pkg::OP_ADD, '0);
    send_token(pse_pkg::OP_PUSH, {1'b1, 47'd0});
    send_token(pse_pkg::OP_SUB, '0);
    send_token(pse_pkg::OP_PUSH, {1'b1, 47'd0});
    send_token(pse_pkg::OP_MUL, '0);
    send_token(pse_pkg::OP_PUSH, 48'h0000_0003_0000);
    send_token(pse_pkg::OP_DIV, '0);
    send_token(pse_pkg::OP_END, '0);
    // Divide by zero, then ignored tokens while the error holds
    send_token(pse_pkg::OP_PUSH, 48'h0000_0001_8000);
    send_token(pse_pkg::OP_PUSH, '0);
    send_token(pse_pkg::OP_DIV, '0);
    send_token(pse_pkg::OP_PUSH, 48'h1);
    send_token(pse_pkg::OP_END, '0);
    // Unknown op codes, each followed by end
    send_token(pse_pkg::OP_PUSH, 48'hFFFF_FFFF_8000);
    send_token(OP_BAD_LO, '0);
    send_token(pse_pkg::OP_END, '0);
    send_token(OP_BAD_HI, '1);
    send_token(pse_pkg::OP_END, '0);
    // Fill to the limit, then one push too many
    for (i = 0; i <= pse_pkg::DEF_STACK_DEPTH; i++) send_token(pse_pkg::OP_PUSH, rand_val());
    send_token(pse_pkg::OP_END, '0);

    for (i = 0; i < RANDOM_EXPRS; i++) send_expression();
    tok_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
